// ===== rtl/p2e_pkg.sv =====
// shared types, constants and angle table for the perspective to equirect map
package p2e_pkg;

   localparam int CfgIdxW = 3;
   typedef enum logic [CfgIdxW-1:0] {
      REG_VIEW_WIDTH  = 3'd0,
      REG_VIEW_HEIGHT = 3'd1,
      REG_FOCAL       = 3'd2,
      REG_PANO_WIDTH  = 3'd3,
      REG_PANO_HEIGHT = 3'd4,
      REG_ROT_ROW0    = 3'd5,
      REG_ROT_ROW1    = 3'd6,
      REG_ROT_ROW2    = 3'd7
   } cfg_reg_type;

   localparam int CoefW   = 18;
   localparam int RowW    = 3 * CoefW;
   localparam int AngW    = 36;
   localparam int CordW   = 64;
   localparam int PrescaleShift = 16;
   localparam logic [16:0] GainQ16 = 17'd107922;
   localparam logic signed [AngW-1:0] HalfTurn = 36'sd2147483648;
   localparam logic signed [AngW-1:0] FullTurn = 36'sd4294967296;

   typedef struct packed {
      logic [12:0] view_width;
      logic [12:0] view_height;
      logic [20:0] focal_q8;
      logic [13:0] pano_width;
      logic [12:0] pano_height;
      logic [RowW-1:0] rot_row0;
      logic [RowW-1:0] rot_row1;
      logic [RowW-1:0] rot_row2;
   } cfg_type;

   // atan(2^-i) in turns * 2^32
   function automatic logic signed [AngW-1:0] atan_turn(input logic [4:0] i);
      logic signed [AngW-1:0] t;
      case (i)
         5'd0:  t = 36'sd536870912;
         5'd1:  t = 36'sd316933406;
         5'd2:  t = 36'sd167458908;
         5'd3:  t = 36'sd85004756;
         5'd4:  t = 36'sd42667331;
         5'd5:  t = 36'sd21354465;
         5'd6:  t = 36'sd10679838;
         5'd7:  t = 36'sd5340245;
         5'd8:  t = 36'sd2670163;
         5'd9:  t = 36'sd1335087;
         5'd10: t = 36'sd667544;
         5'd11: t = 36'sd333772;
         5'd12: t = 36'sd166886;
         5'd13: t = 36'sd83443;
         5'd14: t = 36'sd41722;
         5'd15: t = 36'sd20861;
         5'd16: t = 36'sd10430;
         5'd17: t = 36'sd5215;
         5'd18: t = 36'sd2608;
         5'd19: t = 36'sd1304;
         5'd20: t = 36'sd652;
         5'd21: t = 36'sd326;
         5'd22: t = 36'sd163;
         5'd23: t = 36'sd81;
         5'd24: t = 36'sd41;
         5'd25: t = 36'sd20;
         5'd26: t = 36'sd10;
         5'd27: t = 36'sd5;
         5'd28: t = 36'sd3;
         5'd29: t = 36'sd1;
         5'd30: t = 36'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/p2e_cordic.sv =====
// pipelined cordic vectoring unit, one micro-rotation per stage, with side data
module p2e_cordic #(
   parameter int STEPS = 18,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [p2e_pkg::CordW-1:0] in_a,
   input  logic signed [p2e_pkg::CordW-1:0] in_b,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic signed [p2e_pkg::AngW-1:0]  out_ang,
   output logic signed [p2e_pkg::CordW-1:0] out_mag,
   output logic [SIDE_W-1:0]             out_side
);
   import p2e_pkg::*;

   logic                   v_ff    [STEPS+1];
   logic signed [CordW-1:0] a_ff   [STEPS+1];
   logic signed [CordW-1:0] b_ff   [STEPS+1];
   logic signed [AngW-1:0]  ang_ff [STEPS+1];
   logic                   z_ff    [STEPS+1];
   logic [SIDE_W-1:0]      s_ff    [STEPS+1];

   // stage 0: zero check and half turn pre-rotation
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         z_ff[0] <= (in_a == '0) && (in_b == '0);
         s_ff[0] <= in_side;
         if (in_b < 0) begin
            a_ff[0]   <= -in_a;
            b_ff[0]   <= -in_b;
            ang_ff[0] <= (in_a >= 0) ? HalfTurn : -HalfTurn;
         end else begin
            a_ff[0]   <= in_a;
            b_ff[0]   <= in_b;
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CordW-1:0] da, db;
      logic signed [AngW-1:0]  at;
      assign da = a_ff[i] >>> (i % 32);
      assign db = b_ff[i] >>> (i % 32);
      assign at = atan_turn(5'(i % 32));
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (adv) begin
            z_ff[i+1] <= z_ff[i];
            s_ff[i+1] <= s_ff[i];
            if (a_ff[i] >= 0) begin
               b_ff[i+1]   <= b_ff[i] + da;
               a_ff[i+1]   <= a_ff[i] - db;
               ang_ff[i+1] <= ang_ff[i] + at;
            end else begin
               b_ff[i+1]   <= b_ff[i] - da;
               a_ff[i+1]   <= a_ff[i] + db;
               ang_ff[i+1] <= ang_ff[i] - at;
            end
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_ang   = z_ff[STEPS] ? '0 : ang_ff[STEPS];
   assign out_mag   = z_ff[STEPS] ? '0 : b_ff[STEPS];
   assign out_side  = s_ff[STEPS];
endmodule

// ===== rtl/p2e_rotate.sv =====
// centering and 3x3 matrix rotation, three register stages
module p2e_rotate #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  p2e_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   input  logic [11:0]              pix_u,
   input  logic [11:0]              pix_v,
   output logic                     out_valid,
   output logic signed [39:0]       rx,
   output logic signed [39:0]       ry,
   output logic signed [39:0]       rz
);
   import p2e_pkg::*;

   // centered point, Q.8
   logic              v0_ff;
   logic signed [22:0] p_ff [3];
   // products
   logic              v1_ff;
   logic signed [40:0] m_ff [3][3];
   // rotated components
   logic              v2_ff;
   logic signed [39:0] r_ff [3];

   logic [RowW-1:0] rows [3];
   assign rows[0] = cfg.rot_row0;
   assign rows[1] = cfg.rot_row1;
   assign rows[2] = cfg.rot_row2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= $signed({3'b0, pix_u, 8'b0}) - $signed({3'b0, cfg.view_width, 7'b0});
         p_ff[1] <= $signed({3'b0, pix_v, 8'b0}) - $signed({3'b0, cfg.view_height, 7'b0});
         p_ff[2] <= $signed({2'b0, cfg.focal_q8});
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         logic signed [CoefW-1:0] c;
         assign c = $signed(rows[k][(2-j)*CoefW +: CoefW]);
         always_ff @(posedge clock) begin
            if (adv) m_ff[k][j] <= 41'(c * p_ff[j]);
         end
      end
      logic signed [42:0] acc;
      assign acc = 43'(m_ff[k][0]) + 43'(m_ff[k][1]) + 43'(m_ff[k][2]);
      always_ff @(posedge clock) begin
         if (adv) r_ff[k] <= 40'(acc >>> COEF_FRAC_BITS);
      end
   end

   assign out_valid = v2_ff;
   assign rx = r_ff[0];
   assign ry = r_ff[1];
   assign rz = r_ff[2];
endmodule

// ===== rtl/p2e_pixel.sv =====
// angle to panorama coordinate: clamp, scale, limit, round; three stages
module p2e_pixel #(
   parameter int SIZE_W = 14,
   parameter int Q_W = 21,
   parameter int I_W = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [SIZE_W-1:0]             size,
   input  logic signed [p2e_pkg::AngW+1:0] frac,
   output logic                          out_valid,
   output logic [Q_W-1:0]                q_out,
   output logic [I_W-1:0]                i_out
);
   import p2e_pkg::*;

   localparam logic [Q_W-1:0] QSat = '1;
   localparam logic [I_W-1:0] ISat = '1;

   logic                v0_ff, v1_ff, v2_ff;
   logic [32:0]         f_ff;
   logic [SIZE_W-1:0]   s0_ff, s1_ff;
   logic [SIZE_W+32:0]  prod_ff;
   logic [Q_W-1:0]      q_ff;
   logic [I_W-1:0]      i_ff;

   logic [SIZE_W+32:0]  qa;
   logic signed [SIZE_W+10:0] lim;
   logic [Q_W-1:0]      qc;
   logic [Q_W:0]        ir;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_comb begin
      qa  = (prod_ff + (SIZE_W+33)'(8388608)) >> 24;
      lim = $signed({3'b0, s1_ff, 8'b0}) - (SIZE_W+11)'(384);
      if (lim < 0) begin
         qc = '0;
      end else if (qa > (SIZE_W+33)'($unsigned(lim))) begin
         qc = ((SIZE_W+33)'($unsigned(lim)) > (SIZE_W+33)'(QSat)) ? QSat
                                                                   : Q_W'($unsigned(lim));
      end else begin
         qc = (qa > (SIZE_W+33)'(QSat)) ? QSat : Q_W'(qa);
      end
      ir = ({1'b0, qc} + (Q_W+1)'(128)) >> 8;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (frac < 0)                   f_ff <= '0;
         else if (frac > 38'(FullTurn))  f_ff <= 33'h1_0000_0000;
         else                            f_ff <= frac[32:0];
         s0_ff   <= size;
         prod_ff <= s0_ff * f_ff;
         s1_ff   <= s0_ff;
         q_ff    <= qc;
         i_ff    <= (ir > (Q_W+1)'(ISat)) ? ISat : I_W'(ir);
      end
   end

   assign out_valid = v2_ff;
   assign q_out = q_ff;
   assign i_out = i_ff;
endmodule

// ===== rtl/perspective_to_equirect_map.sv =====
// top level: perspective pixel to equirectangular panorama coordinate map
//
//  channel  dir  handshake          payload
//  req_     in   tvalid/tready      tdata: pix_u[11:0], pix_v[23:12]
//  rsp_     out  tvalid/tready      tdata: x_q8[20:0] y_q8[40:21] x_int[53:41] y_int[65:54]
//  csr_     in   valid/ready        index[2:0], wdata[53:0]
//
// one word per cycle while the output is not stalled; most pipeline stages lie in the
// two cordic pipelines of one micro-rotation per stage each
// reset clears all stage valid bits and loads the register defaults
// the whole pipeline advances when the output register is empty or being taken;
// a stalled output holds every stage, nothing is dropped or repeated
module perspective_to_equirect_map #(
   parameter int CORDIC_STEPS = 18,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pix_u, pix_v
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // pano_x_q8, pano_y_q8, pano_x_int, pano_y_int, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [p2e_pkg::CfgIdxW-1:0] csr_index,
   input  logic [p2e_pkg::RowW-1:0]    csr_wdata
);
   import p2e_pkg::*;

   cfg_type cfg_ff;
   logic    adv;
   logic    out_v_ff;
   logic [65:0] out_d_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_width  <= 13'd512;
         cfg_ff.view_height <= 13'd512;
         cfg_ff.focal_q8    <= 21'd65536;
         cfg_ff.pano_width  <= 14'd1920;
         cfg_ff.pano_height <= 13'd960;
         cfg_ff.rot_row0    <= RowW'(64'd4503599627370496);
         cfg_ff.rot_row1    <= RowW'(64'd17179869184);
         cfg_ff.rot_row2    <= RowW'(64'd65536);
      end else if (csr_valid) begin
         case (cfg_reg_type'(csr_index))
            REG_VIEW_WIDTH:  cfg_ff.view_width  <= csr_wdata[12:0];
            REG_VIEW_HEIGHT: cfg_ff.view_height <= csr_wdata[12:0];
            REG_FOCAL:       cfg_ff.focal_q8    <= csr_wdata[20:0];
            REG_PANO_WIDTH:  cfg_ff.pano_width  <= csr_wdata[13:0];
            REG_PANO_HEIGHT: cfg_ff.pano_height <= csr_wdata[12:0];
            REG_ROT_ROW0:    cfg_ff.rot_row0    <= csr_wdata;
            REG_ROT_ROW1:    cfg_ff.rot_row1    <= csr_wdata;
            REG_ROT_ROW2:    cfg_ff.rot_row2    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   logic               rv;
   logic signed [39:0] rx, ry, rz;

   p2e_rotate #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_rot (
      .clock, .reset, .adv, .cfg(cfg_ff),
      .in_valid(req_tvalid), .pix_u(req_tdata[11:0]), .pix_v(req_tdata[23:12]),
      .out_valid(rv), .rx, .ry, .rz
   );

   logic                   lv;
   logic signed [AngW-1:0] lon;
   logic signed [CordW-1:0] rmag;
   logic signed [39:0]     ry_d;

   p2e_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(40)) u_lon (
      .clock, .reset, .adv, .in_valid(rv),
      .in_a(CordW'(rx) <<< PrescaleShift), .in_b(CordW'(rz) <<< PrescaleShift),
      .in_side(ry), .out_valid(lv), .out_ang(lon), .out_mag(rmag), .out_side(ry_d)
   );

   logic                    tv;
   logic signed [AngW-1:0]  lat, lon_d;
   logic signed [CordW-1:0] unused_mag;
   logic signed [CordW-1:0] ya;
   assign ya = -(CordW'(ry_d) * $signed({1'b0, GainQ16}));

   p2e_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(AngW)) u_lat (
      .clock, .reset, .adv, .in_valid(lv),
      .in_a(ya), .in_b(rmag), .in_side(lon),
      .out_valid(tv), .out_ang(lat), .out_mag(unused_mag), .out_side(lon_d)
   );

   logic signed [AngW+1:0] fx, fy;
   assign fx = (AngW+2)'(HalfTurn) + (AngW+2)'(lon_d);
   assign fy = (AngW+2)'(HalfTurn) - ((AngW+2)'(lat) <<< 1);

   logic        xv, yv;
   logic [20:0] xq;
   logic [19:0] yq;
   logic [12:0] xi;
   logic [11:0] yi;

   p2e_pixel #(.SIZE_W(14), .Q_W(21), .I_W(13)) u_px (
      .clock, .reset, .adv, .in_valid(tv), .size(cfg_ff.pano_width), .frac(fx),
      .out_valid(xv), .q_out(xq), .i_out(xi)
   );
   p2e_pixel #(.SIZE_W(13), .Q_W(20), .I_W(12)) u_py (
      .clock, .reset, .adv, .in_valid(tv), .size(cfg_ff.pano_height), .frac(fy),
      .out_valid(yv), .q_out(yq), .i_out(yi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= xv & yv;
      end
      if (adv) out_d_ff <= {yi, xi, yq, xq};
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'b0, out_d_ff};
endmodule

// ===== tb/sv/perspective_to_equirect_map_tb.sv =====
// testbench for the perspective to equirect coordinate map
`timescale 1ns / 1ps

module perspective_to_equirect_map_tb;
   import p2e_pkg::*;

   typedef struct packed {
      logic [11:0] pano_y_int;
      logic [12:0] pano_x_int;
      logic [19:0] pano_y_q8;
      logic [20:0] pano_x_q8;
   } pano_coord_type;

   localparam longint HalfTurnL = 64'sd2147483648;
   localparam longint FullTurnL = 64'sd4294967296;
   localparam int     CycleLimit = 2000000;
   localparam int     PhaseItems = 136;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CfgIdxW-1:0] csr_index = '0;
   logic [RowW-1:0]    csr_wdata = '0;

   logic [23:0]     pixel_queue[$];
   pano_coord_type  coord_queue[$];
   cfg_type         active_cfg;
   longint          angle_table[32];
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              hold_off = 0;
   logic            holding = 1'b0;
   event            hold_go;
   int              errors = 0;
   int              cycles = 0;

   perspective_to_equirect_map i_dut (.*);

   always #5 clock = ~clock;

   function automatic longint coef_at(logic [RowW-1:0] row, int pos);
      logic signed [CoefW-1:0] c;
      c = row[pos +: CoefW];
      return longint'(c);
   endfunction

   // vectoring cordic: angle of (b, a) in turns * 2^32, mag gets gain * |(a,b)|
   function automatic longint vector_angle(longint a_in, longint b_in, output longint mag);
      longint a, b, ang, da, db;
      a = a_in;
      b = b_in;
      ang = 0;
      mag = 0;
      if (a == 0 && b == 0) return 0;
      if (b < 0) begin
         ang = (a >= 0) ? HalfTurnL : -HalfTurnL;
         a = -a;
         b = -b;
      end
      for (int i = 0; i < 18; i++) begin
         da = a >>> i;
         db = b >>> i;
         if (a >= 0) begin
            b += da;
            a -= db;
            ang += angle_table[i];
         end else begin
            b -= da;
            a += db;
            ang -= angle_table[i];
         end
      end
      mag = b;
      return ang;
   endfunction

   function automatic longint scale_to_pixel(longint size, longint frac, longint sat);
      longint f, q, lim;
      f = frac < 0 ? 0 : (frac > FullTurnL ? FullTurnL : frac);
      q = (size * f + 64'sd8388608) >>> 24;
      lim = size * 256 - 384;
      if (q > lim) q = lim;
      if (q < 0) q = 0;
      if (q > sat) q = sat;
      return q;
   endfunction

   function automatic pano_coord_type map_pixel(logic [23:0] word, cfg_type c);
      longint p[3], r[3], acc, lon, lat, rmag, unused, xq, yq, xi, yi;
      logic [RowW-1:0] rows[3];
      pano_coord_type o;
      rows[0] = c.rot_row0;
      rows[1] = c.rot_row1;
      rows[2] = c.rot_row2;
      p[0] = longint'(word[11:0]) * 256 - longint'(c.view_width) * 128;
      p[1] = longint'(word[23:12]) * 256 - longint'(c.view_height) * 128;
      p[2] = longint'(c.focal_q8);
      for (int k = 0; k < 3; k++) begin
         acc = coef_at(rows[k], 36) * p[0] + coef_at(rows[k], 18) * p[1]
             + coef_at(rows[k], 0) * p[2];
         r[k] = acc >>> 16;
      end
      lon = vector_angle(r[0] * 65536, r[2] * 65536, rmag);
      lat = vector_angle(-r[1] * 107922, rmag, unused);
      xq = scale_to_pixel(longint'(c.pano_width), HalfTurnL + lon, 2097151);
      yq = scale_to_pixel(longint'(c.pano_height), HalfTurnL - 2 * lat, 1048575);
      xi = (xq + 128) >>> 8;
      yi = (yq + 128) >>> 8;
      if (xi > 8191) xi = 8191;
      if (yi > 4095) yi = 4095;
      o.pano_x_q8 = xq[20:0];
      o.pano_y_q8 = yq[19:0];
      o.pano_x_int = xi[12:0];
      o.pano_y_int = yi[11:0];
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // driver: takes words from the pixel queue, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) coord_queue.push_back(map_pixel(req_tdata, active_cfg));
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= pixel_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the pipeline fills and stalls the input
   always begin
      @(hold_go);
      holding <= 1'b1;
      for (hold_off = 400; hold_off > 0; hold_off--) @(posedge clock);
      holding <= 1'b0;
   end

   // monitor: compares each result word with the oldest prediction
   always @(posedge clock) begin
      pano_coord_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[65:0];
         if (coord_queue.size() == 0) begin
            report("unexpected word", 64'(got.pano_x_q8), 64'd0);
         end else begin
            want = coord_queue.pop_front();
            if (got.pano_x_q8 != want.pano_x_q8) report("pano_x_q8", got.pano_x_q8, want.pano_x_q8);
            if (got.pano_y_q8 != want.pano_y_q8) report("pano_y_q8", got.pano_y_q8, want.pano_y_q8);
            if (got.pano_x_int != want.pano_x_int)
               report("pano_x_int", got.pano_x_int, want.pano_x_int);
            if (got.pano_y_int != want.pano_y_int)
               report("pano_y_int", got.pano_y_int, want.pano_y_int);
         end
      end
      if (holding) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(cfg_reg_type idx, logic [RowW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         REG_VIEW_WIDTH:  active_cfg.view_width = val[12:0];
         REG_VIEW_HEIGHT: active_cfg.view_height = val[12:0];
         REG_FOCAL:       active_cfg.focal_q8 = val[20:0];
         REG_PANO_WIDTH:  active_cfg.pano_width = val[13:0];
         REG_PANO_HEIGHT: active_cfg.pano_height = val[12:0];
         REG_ROT_ROW0:    active_cfg.rot_row0 = val;
         REG_ROT_ROW1:    active_cfg.rot_row1 = val;
         default:         active_cfg.rot_row2 = val;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic program_all(cfg_type c);
      write_reg(REG_VIEW_WIDTH, RowW'(c.view_width));
      write_reg(REG_VIEW_HEIGHT, RowW'(c.view_height));
      write_reg(REG_FOCAL, RowW'(c.focal_q8));
      write_reg(REG_PANO_WIDTH, RowW'(c.pano_width));
      write_reg(REG_PANO_HEIGHT, RowW'(c.pano_height));
      write_reg(REG_ROT_ROW0, c.rot_row0);
      write_reg(REG_ROT_ROW1, c.rot_row1);
      write_reg(REG_ROT_ROW2, c.rot_row2);
   endtask

   function automatic logic [RowW-1:0] pack_row(int c0, int c1, int c2);
      logic [CoefW-1:0] a, b, d;
      a = c0[CoefW-1:0];
      b = c1[CoefW-1:0];
      d = c2[CoefW-1:0];
      return {a, b, d};
   endfunction

   function automatic logic [RowW-1:0] random_row();
      if ($urandom_range(1)) return RowW'({$urandom, $urandom});
      return pack_row($signed($urandom_range(131072)) - 65536,
                      $signed($urandom_range(131072)) - 65536,
                      $signed($urandom_range(131072)) - 65536);
   endfunction

   initial begin
      cfg_type c;
      int u_hi, v_hi;
      angle_table = '{536870912, 316933406, 167458908, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                      10, 5, 3, 1, 1, 0};
      active_cfg = '{13'd512, 13'd512, 21'd65536, 14'd1920, 13'd960,
                     pack_row(65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, 65536)};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 11; ph++) begin
         c = active_cfg;
         case (ph)
            0: ;
            1: c = '{13'd1, 13'd1, 21'd1, 14'd2, 13'd2,
                     pack_row(65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, 65536)};
            2: c = '{13'd4096, 13'd4096, 21'h1FFFFF, 14'd8192, 13'd4096,
                     random_row(), random_row(), random_row()};
            // oversize panorama saturates the outputs
            3: c = '{13'h1FFF, 13'h1FFF, 21'd300000, 14'h3FFF, 13'h1FFF,
                     pack_row(131071, -131072, 0), pack_row(0, 65536, 0),
                     pack_row(0, 0, 65536)};
            // zero depth hits the zero vector, panorama below two clamps to zero
            4: c = '{13'd2048, 13'd2048, 21'd0, 14'd1, 13'd0,
                     pack_row(65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, 65536)};
            // negative depth needs the half-turn pre-rotation
            5: c = '{13'd640, 13'd480, 21'd80000, 14'd4096, 13'd2048,
                     pack_row(-65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, -65536)};
            default: begin
               c.view_width = 13'($urandom_range(4096, 1));
               c.view_height = 13'($urandom_range(4096, 1));
               c.focal_q8 = ($urandom_range(3) == 0) ? 21'($urandom_range(2097151))
                                                     : 21'($urandom_range(524288, 8192));
               c.pano_width = 14'($urandom_range(8192, 2));
               c.pano_height = 13'($urandom_range(4096, 2));
               c.rot_row0 = random_row();
               c.rot_row1 = random_row();
               c.rot_row2 = random_row();
            end
         endcase
         if (ph > 0) program_all(c);
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 82 : 7) : 0;
         recv_stall_pct = (ph % 4 == 2) ? 82 : ((ph % 4 == 3) ? 7 : 0);
         if (ph == 4 || ph == 8) -> hold_go;

         u_hi = (c.view_width > 4096 || c.view_width == 0) ? 4095 : c.view_width - 1;
         v_hi = (c.view_height > 4096 || c.view_height == 0) ? 4095 : c.view_height - 1;
         pixel_queue.push_back({12'd0, 12'd0});
         pixel_queue.push_back({12'hFFF, 12'hFFF});
         pixel_queue.push_back({12'hFFF, 12'd0});
         pixel_queue.push_back({12'd0, 12'hFFF});
         pixel_queue.push_back({c.view_height[12:1], c.view_width[12:1]});
         for (int n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(3) == 0)
               pixel_queue.push_back(24'($urandom_range(24'hFFFFFF)));
            else
               pixel_queue.push_back({12'($urandom_range(v_hi)), 12'($urandom_range(u_hi))});
         end
         while (pixel_queue.size() != 0 || req_tvalid || coord_queue.size() != 0)
            @(posedge clock);
      end

      repeat (60) @(posedge clock);
      if (errors == 0 && coord_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/p2e_pkg.sv
rtl/p2e_cordic.sv
rtl/p2e_rotate.sv
rtl/p2e_pixel.sv
rtl/perspective_to_equirect_map.sv
tb/sv/perspective_to_equirect_map_tb.sv
